>>> hdl/urf_pkg.sv
// shared types, constants and register codes of the ultrasonic range filter
package urf_pkg;

    // group geometry
    localparam int GROUP_SIZE_DEF = 5;

    // field widths
    localparam int ECHO_W     = 16;
    localparam int TEMP_W     = 6;
    localparam int DIST_W     = 13;
    localparam int KEY_W      = 14;
    localparam int SPEED_W    = 19;
    localparam int PROD_W     = 35;
    localparam int QUOT_W     = 15;
    localparam int BIT_W      = 1;
    localparam int OFS_W      = 9;
    localparam int SHIFT_W    = 3;
    localparam int CM_W       = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // conversion: echo * (331300 + 606 * temp) / 1250000
    localparam logic [SPEED_W-1:0] SPEED_BASE  = SPEED_W'(331300);
    localparam logic [9:0]         SPEED_SLOPE = 10'd606;

    // 1250000 = 16 * 78125: drop four bits, then multiply the 31 bit rest by
    // ceil(2^48 / 78125) and keep bits 62..48, exact for every 31 bit value;
    // the multiply runs in two 16 bit halves, low half first
    localparam int PRE_SHIFT   = 4;
    localparam int SCALED_W    = PROD_W - PRE_SHIFT;
    localparam int HALF_W      = 16;
    localparam int HI_W        = SCALED_W - HALF_W;
    localparam int RECIP_W     = 32;
    localparam int PART_W      = HALF_W + RECIP_W;
    localparam int ACC_W       = SCALED_W + RECIP_W;
    localparam int RECIP_SHIFT = 48;
    localparam logic [RECIP_W-1:0] RECIP   = 32'd3602879702;
    localparam logic [BIT_W-1:0]   TOP_BIT = BIT_W'(1);

    // sample window and sort key for rejected samples
    localparam logic [QUOT_W-1:0] DIST_MIN_VALID = QUOT_W'(16);
    localparam logic [QUOT_W-1:0] DIST_MAX_VALID = QUOT_W'(8000);
    localparam logic [KEY_W-1:0]  INVALID_KEY    = KEY_W'(8192);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SHIFT  = 3'd4;

    // register reset values
    localparam logic [DIST_W-1:0]  RST_MIN_DISTANCE = 13'd80;
    localparam logic [DIST_W-1:0]  RST_MAX_DISTANCE = 13'd3200;
    localparam logic [OFS_W-1:0]   RST_CAL_OFFSET   = 9'h1FC;
    localparam logic [DIST_W-1:0]  RST_JUMP_LIMIT   = 13'd320;
    localparam logic [SHIFT_W-1:0] RST_ALPHA_SHIFT  = 3'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_AVERAGED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_HELD      = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             first;
        logic             mul;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             store;
        logic             sort;
        logic             sort_odd;
        logic             eval;
    } t_cmd;

endpackage

>>> hdl/urf_ctrl.sv
// sequencer for sample conversion, group sort and result evaluation
module urf_ctrl #(
    parameter int GROUP_SIZE = urf_pkg::GROUP_SIZE_DEF,
    localparam int IDX_W = $clog2(GROUP_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output urf_pkg::t_cmd    o_cmd,
    output logic [IDX_W-1:0] o_index
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_SORT  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(GROUP_SIZE - 1);

    logic [2:0]                 r_state, n_state;
    logic [IDX_W-1:0]           r_index, n_index;
    logic [IDX_W-1:0]           r_pass, n_pass;
    logic [urf_pkg::BIT_W-1:0]  r_bit, n_bit;

    assign busy    = (r_state != S_IDLE);
    assign o_index = r_index;

    always_comb begin
        n_state = r_state;
        n_index = r_index;
        n_pass  = r_pass;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.div_bit  = r_bit;
        o_cmd.sort_odd = r_pass[0];
        o_cmd.first    = (r_index == '0);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_bit     = urf_pkg::TOP_BIT;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_index == LAST) begin
                    n_index = '0;
                    n_pass  = '0;
                    n_state = S_SORT;
                end else begin
                    n_index = r_index + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SORT: begin
                o_cmd.sort = 1'b1;
                if (r_pass == LAST) begin
                    n_state = S_EVAL;
                end else begin
                    n_pass = r_pass + 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_index <= '0;
            r_pass  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_index <= n_index;
            r_pass  <= n_pass;
            r_bit   <= n_bit;
        end
    end

    // results only come out once a group has wrapped the sample index
    a_eval_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVAL |-> r_index == '0)
        else $error("evaluation with a partial group");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == S_MUL)
        else $error("accepted word did not enter the multiply step");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STORE |-> $past(r_state) == S_DIV && $past(r_bit) == '0)
        else $error("sample stored before all quotient bits were formed");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.mul, o_cmd.div_step, o_cmd.store, o_cmd.sort, o_cmd.eval}))
        else $error("more than one datapath command at once");

endmodule

>>> hdl/urf_datapath.sv
// conversion by reciprocal multiply, sample keys, median sort, smoothing and config registers
module urf_datapath #(
    parameter int GROUP_SIZE = urf_pkg::GROUP_SIZE_DEF,
    localparam int IDX_W = $clog2(GROUP_SIZE)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  urf_pkg::t_cmd                   i_cmd,
    input  logic [IDX_W-1:0]                i_index,
    input  logic [urf_pkg::ECHO_W-1:0]      i_echo_time,
    input  logic                            i_echo_ok,
    input  logic [urf_pkg::TEMP_W-1:0]      i_temperature,
    input  logic                            i_cfg_we,
    input  logic [urf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [urf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic                            o_strobe,
    output logic [urf_pkg::STATUS_W-1:0]    o_status,
    output logic [urf_pkg::CM_W-1:0]        o_distance_cm,
    output logic                            o_jump_skipped
);

    localparam int CNT_W = $clog2(GROUP_SIZE + 1);
    localparam int MID   = GROUP_SIZE / 2;
    localparam int DW    = urf_pkg::DIST_W;
    localparam int KW    = urf_pkg::KEY_W;
    localparam int CW    = KW + 1;

    // config registers
    logic [DW-1:0]                   r_min_distance;
    logic [DW-1:0]                   r_max_distance;
    logic [urf_pkg::OFS_W-1:0]       r_cal_offset;
    logic [DW-1:0]                   r_jump_limit;
    logic [urf_pkg::SHIFT_W-1:0]     r_alpha_shift;

    // conversion
    logic [urf_pkg::ECHO_W-1:0]      r_echo;
    logic                            r_ok;
    logic [urf_pkg::SPEED_W-1:0]     r_sound_speed;
    logic [urf_pkg::PROD_W-1:0]      r_prod;
    logic [urf_pkg::ACC_W-1:0]       r_acc;
    logic [urf_pkg::HALF_W-1:0]      x_lo;
    logic [urf_pkg::HI_W-1:0]        x_hi;
    logic [urf_pkg::HALF_W-1:0]      x_half;
    logic [urf_pkg::PART_W-1:0]      part;
    logic [urf_pkg::QUOT_W-1:0]      quot;
    logic                            sample_ok;

    // group
    logic [KW-1:0]                   r_key [GROUP_SIZE];
    logic [KW-1:0]                   n_key [GROUP_SIZE];
    logic [CNT_W-1:0]                r_valid_cnt;

    // smoothing state
    logic [DW-1:0]                   r_average;
    logic                            r_avg_present;

    // evaluation
    logic [KW-1:0]                   med;
    logic                            have;
    logic signed [CW-1:0]            corr;
    logic [KW-1:0]                   corr_u;
    logic                            too_close, out_range, negative;
    logic [DW-1:0]                   cv, mag, step_v, n_average;
    logic                            n_present, n_skip;
    logic [urf_pkg::STATUS_W-1:0]    n_status;
    logic [DW-1:0]                   round_src;
    logic [KW-1:0]                   round_sum;
    logic [urf_pkg::CM_W-1:0]        round_cm;

    // product split into the halves of the reciprocal multiply
    assign x_lo   = r_prod[urf_pkg::PRE_SHIFT +: urf_pkg::HALF_W];
    assign x_hi   = r_prod[urf_pkg::PROD_W-1:urf_pkg::PRE_SHIFT+urf_pkg::HALF_W];
    assign x_half = (i_cmd.div_bit == urf_pkg::TOP_BIT) ? x_lo : urf_pkg::HALF_W'(x_hi);
    assign part   = urf_pkg::PART_W'(x_half) * urf_pkg::PART_W'(urf_pkg::RECIP);
    assign quot   = r_acc[urf_pkg::ACC_W-1:urf_pkg::RECIP_SHIFT];

    assign sample_ok = r_ok && (quot >= urf_pkg::DIST_MIN_VALID)
                       && (quot <= urf_pkg::DIST_MAX_VALID);

    // one odd-even transposition pass
    always_comb begin
        n_key = r_key;
        for (int i = 0; i < GROUP_SIZE - 1; i++) begin
            if ((i % 2) == int'(i_cmd.sort_odd) && r_key[i+1] < r_key[i]) begin
                n_key[i]   = r_key[i+1];
                n_key[i+1] = r_key[i];
            end
        end
    end

    // classification and average update
    always_comb begin
        med       = r_key[MID];
        have      = (r_valid_cnt >= CNT_W'(3)) && (med < urf_pkg::INVALID_KEY);
        corr      = have ? ($signed({1'b0, med}) + CW'($signed(r_cal_offset)))
                         : -CW'(1);
        corr_u    = corr[KW-1:0];
        negative  = corr[CW-1];
        too_close = !negative && (corr_u != '0) && (corr_u < {1'b0, r_min_distance});
        out_range = !negative && (corr_u != '0) && (corr_u > {1'b0, r_max_distance});
        cv        = corr_u[DW-1:0];
        mag       = (cv >= r_average) ? (cv - r_average) : (r_average - cv);
        step_v    = mag >> r_alpha_shift;
        n_average = r_average;
        n_present = r_avg_present;
        n_skip    = 1'b0;
        n_status  = urf_pkg::ST_AVERAGED;
        round_src = r_average;
        if (too_close) begin
            n_status  = urf_pkg::ST_TOO_CLOSE;
            n_present = 1'b0;
        end else if (out_range) begin
            n_status  = urf_pkg::ST_OUT_RANGE;
            n_present = 1'b0;
        end else if (negative) begin
            n_status = r_avg_present ? urf_pkg::ST_HELD : urf_pkg::ST_OUT_RANGE;
        end else begin
            if (!r_avg_present) begin
                n_average = cv;
                n_present = 1'b1;
            end else if (mag <= r_jump_limit) begin
                n_average = (cv >= r_average) ? (r_average + step_v) : (r_average - step_v);
            end else begin
                n_skip = 1'b1;
            end
            round_src = n_average;
        end
        round_sum = {1'b0, round_src} + KW'(8);
        round_cm  = (round_sum[KW-1:4] > 10'd511) ? '1 : round_sum[KW-2:4];
    end

    // config registers, sound speed, valid count, smoothing state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_distance <= urf_pkg::RST_MIN_DISTANCE;
            r_max_distance <= urf_pkg::RST_MAX_DISTANCE;
            r_cal_offset   <= urf_pkg::RST_CAL_OFFSET;
            r_jump_limit   <= urf_pkg::RST_JUMP_LIMIT;
            r_alpha_shift  <= urf_pkg::RST_ALPHA_SHIFT;
            r_sound_speed  <= '0;
            r_average      <= '0;
            r_avg_present  <= 1'b0;
            r_valid_cnt    <= '0;
            o_strobe       <= 1'b0;
        end else begin
            o_strobe <= i_cmd.eval;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    urf_pkg::REG_MIN_DISTANCE: r_min_distance <= i_cfg_wdata;
                    urf_pkg::REG_MAX_DISTANCE: r_max_distance <= i_cfg_wdata;
                    urf_pkg::REG_CAL_OFFSET:   r_cal_offset   <= i_cfg_wdata[urf_pkg::OFS_W-1:0];
                    urf_pkg::REG_JUMP_LIMIT:   r_jump_limit   <= i_cfg_wdata;
                    urf_pkg::REG_ALPHA_SHIFT:  r_alpha_shift  <= i_cfg_wdata[urf_pkg::SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && i_cmd.first) begin
                r_sound_speed <= urf_pkg::SPEED_BASE
                    + urf_pkg::SPEED_W'(urf_pkg::SPEED_SLOPE) * urf_pkg::SPEED_W'(i_temperature);
            end
            if (i_cmd.store) begin
                r_valid_cnt <= (i_index == '0) ? CNT_W'(sample_ok)
                                               : r_valid_cnt + CNT_W'(sample_ok);
            end
            if (i_cmd.eval) begin
                r_average     <= n_average;
                r_avg_present <= n_present;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_echo <= i_echo_time;
            r_ok   <= i_echo_ok;
        end
        if (i_cmd.mul) begin
            r_prod <= urf_pkg::PROD_W'(r_echo) * urf_pkg::PROD_W'(r_sound_speed);
        end
        // low half first, then the high half added sixteen bits up
        if (i_cmd.div_step) begin
            if (i_cmd.div_bit == urf_pkg::TOP_BIT) begin
                r_acc <= urf_pkg::ACC_W'(part);
            end else begin
                r_acc <= r_acc + {part[urf_pkg::ACC_W-urf_pkg::HALF_W-1:0],
                                  {urf_pkg::HALF_W{1'b0}}};
            end
        end
        if (i_cmd.store) begin
            r_key[i_index] <= sample_ok ? {1'b0, quot[DW-1:0]} : urf_pkg::INVALID_KEY;
        end
        if (i_cmd.sort) begin
            r_key <= n_key;
        end
        if (i_cmd.eval) begin
            o_status       <= n_status;
            o_distance_cm  <= (n_status == urf_pkg::ST_AVERAGED || n_status == urf_pkg::ST_HELD)
                              ? round_cm : '0;
            o_jump_skipped <= n_skip;
        end
    end

endmodule

>>> hdl/ultrasonic_range_filter.sv
// top level of the ultrasonic range filter: controller plus datapath
// conversion: a word accepted on start passes through multiply, a two-step
//   reciprocal multiply for the divide by 1250000, and store; busy is high while these run
// a new word is accepted only once busy is low again; the last word of a group adds
//   GROUP_SIZE sort passes and an evaluation step, and o_strobe follows in the next cycle
// reset: synchronous active low; config returns to defaults, average cleared
// o_strobe marks a result for one cycle; the receiver cannot stall it
module ultrasonic_range_filter #(
    parameter int GROUP_SIZE = urf_pkg::GROUP_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample word
    input  logic                            start,
    output logic                            busy,
    input  logic [urf_pkg::ECHO_W-1:0]      i_echo_time,
    input  logic                            i_echo_ok,
    input  logic [urf_pkg::TEMP_W-1:0]      i_temperature,
    // config write port
    input  logic                            i_cfg_we,
    input  logic [urf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [urf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // result word
    output logic                            o_strobe,
    output logic [urf_pkg::STATUS_W-1:0]    o_status,
    output logic [urf_pkg::CM_W-1:0]        o_distance_cm,
    output logic                            o_jump_skipped
);

    localparam int IDX_W = $clog2(GROUP_SIZE);

    // commands from the sequencer and the slot of the current sample
    urf_pkg::t_cmd     cmd;
    logic [IDX_W-1:0]  sample_index;

    // sequencer: idle -> multiply -> divide -> store, and at group end
    // sort passes -> evaluate
    urf_ctrl #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_index (sample_index)
    );

    // arithmetic, sample keys, median and smoothing
    urf_datapath #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_index        (sample_index),
        .i_echo_time    (i_echo_time),
        .i_echo_ok      (i_echo_ok),
        .i_temperature  (i_temperature),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_distance_cm  (o_distance_cm),
        .o_jump_skipped (o_jump_skipped)
    );

endmodule
